/* hw/rtl/spq_pkg.sv */
// spq_pkg: shared types, codes and helpers for the severity priority queue
// no dependencies; used by the channel interfaces, the cell and the top level
`timescale 1ns / 1ps

package spq_pkg;

   localparam int unsigned SEV_W = 4;
   localparam int unsigned AGE_W = 8;
   localparam int unsigned PID_W = 37;
   localparam int unsigned OCC_W = 5;
   localparam int unsigned STATUS_W = 2;

   localparam logic [SEV_W-1:0] SEV_MIN = SEV_W'(1);
   localparam logic [SEV_W-1:0] SEV_MAX = SEV_W'(10);

   // item kinds
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_POP    = 1'b1
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one stored queue entry
   typedef struct packed {
      logic [SEV_W-1:0] severity;
      logic [AGE_W-1:0] age;
      logic [PID_W-1:0] patient_id;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic do_insert;
      logic do_pop;
   } cell_ctrl_type;

   // clamp a raw severity into the legal range
   function automatic logic [SEV_W-1:0] clamp_severity(input logic [SEV_W-1:0] raw);
      logic [SEV_W-1:0] res;
      res = raw;
      if (raw < SEV_MIN) begin
         res = SEV_MIN;
      end else if (raw > SEV_MAX) begin
         res = SEV_MAX;
      end
      return res;
   endfunction

endpackage

/* hw/rtl/spq_channels.sv */
// spq_req_if and spq_rsp_if: valid/ready channels of the priority queue
// depends on spq_pkg for field widths
`timescale 1ns / 1ps

interface spq_req_if
   import spq_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [SEV_W-1:0] severity;
   logic [AGE_W-1:0] age;
   logic [PID_W-1:0] patient_id;

   modport source (output valid, kind, severity, age, patient_id, input ready);
   modport sink   (input valid, kind, severity, age, patient_id, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SEV_W-1:0]    out_severity;
   logic [AGE_W-1:0]    out_age;
   logic [PID_W-1:0]    out_patient_id;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_severity, out_age, out_patient_id, occupancy,
                   input ready);
   modport sink   (input valid, status, out_severity, out_age, out_patient_id, occupancy,
                   output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// spq_cell: one slot of the sorted queue, compares and shifts with its neighbors
// depends on spq_pkg for entry and control types
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_keep,
   input  entry_type     right_entry,
   input  logic          occupied,
   output entry_type     entry,
   output logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // an occupied slot with equal or higher severity stays ahead of the new entry
   assign keep = occupied && (entry_ff.severity >= new_entry.severity);

   // next slot contents: hold, take the new entry, shift in from left or right
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert && !keep) begin
         if (left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.do_pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* hw/rtl/severity_priority_queue.sv */
// severity_priority_queue: top level, a row of compare-and-shift cells plus result register
// depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell
//
//   channel   | dir | carries
//   ----------+-----+-----------------------------------------------------
//   req_chan  | in  | kind, severity, age, patient_id
//   rsp_chan  | out | status, out_severity, out_age, out_patient_id, occupancy
//
// one item per cycle while the result side keeps up; its result is registered and shows in the cycle after the transfer
// every cell compares and shifts in the same cycle, set by one severity compare per cell
// reset clears the fill count and the result valid flag; slot contents need no clearing
// a new item is taken while the result register is empty or being drained
`timescale 1ns / 1ps

module severity_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       rsp_status_ff;
   status_type       rsp_status_in;
   entry_type        rsp_entry_ff;
   entry_type        rsp_entry_in;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic [OCC_W-1:0] rsp_occ_in;

   logic          accept;
   logic          is_pop;
   logic          is_full;
   logic          is_empty;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [QUEUE_DEPTH];
   logic          cell_keep  [QUEUE_DEPTH];

   // input transfer
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_pop         = (kind_type'(req_chan.kind) == KIND_POP);
   assign is_full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty       = (count_ff == '0);

   // command to the cell row
   assign ctrl.do_insert = accept && !is_pop && !is_full;
   assign ctrl.do_pop    = accept && is_pop && !is_empty;

   assign new_entry.severity   = clamp_severity(req_chan.severity);
   assign new_entry.age        = req_chan.age;
   assign new_entry.patient_id = req_chan.patient_id;

   // row of cells, slot 0 is the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;
      logic      occ;

      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_k = 1'b1;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_k = cell_keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      assign occ = (CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .occupied    (occ),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (ctrl.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result register contents
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_entry_in  = '0;
         rsp_occ_in    = OCC_W'(count_in);
         if (is_pop) begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_entry_in = cell_entry[0];
            end
         end else if (is_full) begin
            rsp_status_in = ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // output transfer
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.out_severity   = rsp_entry_ff.severity;
   assign rsp_chan.out_age        = rsp_entry_ff.age;
   assign rsp_chan.out_patient_id = rsp_entry_ff.patient_id;
   assign rsp_chan.occupancy      = rsp_occ_ff;

`ifndef SYNTHESIS
   // fill count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   // a pending result reports the current fill count
   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_occ_ff == OCC_W'(count_ff)))
      else $error("reported occupancy differs from fill count");

   // full status only when every slot is in use
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("full status with free slots");

   // empty status only on an empty queue, with zeroed fields
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (count_ff == '0 && rsp_entry_ff == '0))
      else $error("empty status on a non-empty queue");

   // a successful pop shrinks the queue by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.do_pop |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not decrement fill count");
`endif

endmodule

/* bench/spq_bench_pkg.sv */
// spq_bench_pkg: triage queue tracker that predicts and checks every queue result
// depends on spq_pkg for field widths, item kinds, status codes and the entry layout
`timescale 1ns / 1ps

package spq_bench_pkg;
   import spq_pkg::*;

   localparam int unsigned WARD_DEPTH = 16;

   // one predicted result
   typedef struct {
      status_type       status;
      logic [SEV_W-1:0] severity;
      logic [AGE_W-1:0] age;
      logic [PID_W-1:0] patient_id;
      logic [OCC_W-1:0] occupancy;
   } triage_outcome_type;

   class triage_tracker;
      entry_type          ward[$];
      triage_outcome_type awaited[$];
      int                 mismatches;

      function new();
         mismatches = 0;
      endfunction

      // work out the result of one accepted request and keep the ward in step
      function void admit(kind_type kind, logic [SEV_W-1:0] raw_sev,
                          logic [AGE_W-1:0] age, logic [PID_W-1:0] pid);
         triage_outcome_type o;
         entry_type          e;
         int                 slot;
         o.status = ST_OK;
         o.severity = '0;
         o.age = '0;
         o.patient_id = '0;
         if (kind == KIND_INSERT) begin
            // clamp into the legal severity band
            e.severity = raw_sev;
            if (raw_sev < SEV_MIN) begin
               e.severity = SEV_MIN;
            end else if (raw_sev > SEV_MAX) begin
               e.severity = SEV_MAX;
            end
            e.age = age;
            e.patient_id = pid;
            if (ward.size() >= WARD_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               // behind every entry of equal or higher severity
               slot = 0;
               while (slot < ward.size() && ward[slot].severity >= e.severity) slot++;
               ward.insert(slot, e);
            end
         end else if (ward.size() == 0) begin
            o.status = ST_EMPTY;
         end else begin
            e = ward.pop_front();
            o.severity = e.severity;
            o.age = e.age;
            o.patient_id = e.patient_id;
         end
         o.occupancy = OCC_W'(ward.size());
         awaited.push_back(o);
      endfunction

      function void match_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check(logic [STATUS_W-1:0] status, logic [SEV_W-1:0] severity,
                          logic [AGE_W-1:0] age, logic [PID_W-1:0] pid,
                          logic [OCC_W-1:0] occupancy);
         triage_outcome_type o;
         if (awaited.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
            return;
         end
         o = awaited.pop_front();
         match_field("status", o.status, status);
         match_field("out_severity", o.severity, severity);
         match_field("out_age", o.age, age);
         match_field("out_patient_id", o.patient_id, pid);
         match_field("occupancy", o.occupancy, occupancy);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
// tb_top: directed and random regression of severity_priority_queue with random stalls
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_bench_pkg and the queue RTL
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;
   import spq_bench_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_OFF_CYCLES = 100;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   triage_tracker tracker;
   int            results_seen = 0;
   bit            sender_calm = 1'b0;
   bit            receiver_calm = 1'b0;

   severity_priority_queue #(.QUEUE_DEPTH(WARD_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none in a calm stretch
   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one request after a random gap and wait for its transfer
   task automatic offer_item(kind_type kind, logic [SEV_W-1:0] sev,
                             logic [AGE_W-1:0] age, logic [PID_W-1:0] pid);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= kind;
      req_chan.severity   <= sev;
      req_chan.age        <= age;
      req_chan.patient_id <= pid;
      do @(posedge clock); while (!req_chan.ready);
      tracker.admit(kind, sev, age, pid);
   endtask

   // random content; some severities packed into a narrow band to force ties
   task automatic offer_random(int insert_pct);
      logic [63:0]      wide;
      logic [SEV_W-1:0] sev;
      kind_type         kind;
      wide = {$urandom(), $urandom()};
      sev = ($urandom_range(0, 9) < 3) ? SEV_W'($urandom_range(4, 6))
                                       : SEV_W'($urandom_range(0, 15));
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
      offer_item(kind, sev, AGE_W'($urandom_range(0, 255)), wide[PID_W-1:0]);
   endtask

   // result side: random ready, one long hold-off once traffic is flowing
   initial begin
      int  stall;
      bit  hold_off_done;
      hold_off_done = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen % 50 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         stall = pick_gap(receiver_calm);
         if (!hold_off_done && results_seen >= 60) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tracker.check(rsp_chan.status, rsp_chan.out_severity, rsp_chan.out_age,
                       rsp_chan.out_patient_id, rsp_chan.occupancy);
         results_seen++;
      end
   end

   // main sequence
   initial begin
      int sent;
      int burst;
      int bias_sel;
      int insert_pct;
      tracker = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_INSERT;
      req_chan.severity = '0;
      req_chan.age = '0;
      req_chan.patient_id = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, clamping at both ends, field extremes, equal-severity order
      offer_item(KIND_POP, '0, '0, '0);
      offer_item(KIND_INSERT, 4'd0, 8'd0, '0);
      offer_item(KIND_INSERT, 4'd15, 8'd255, '1);
      offer_item(KIND_INSERT, 4'd10, 8'd17, 37'd1);
      offer_item(KIND_INSERT, 4'd11, 8'd33, 37'h10_0000_0000);
      offer_item(KIND_INSERT, 4'd1, 8'd128, 37'd99999999999);
      offer_item(KIND_INSERT, 4'd5, 8'd1, 37'h0A_AAAA_AAAA);
      offer_item(KIND_INSERT, 4'd5, 8'd2, 37'h15_5555_5555);
      offer_item(KIND_INSERT, 4'd5, 8'd3, 37'd3);
      offer_item(KIND_INSERT, 4'd9, 8'd254, 37'd42);
      repeat (10) offer_item(KIND_POP, 4'd15, 8'd255, '1);

      // random bursts cycling through filling, balanced and draining mixes
      sent = 0;
      bias_sel = 0;
      while (sent < RANDOM_ITEMS) begin
         case (bias_sel % 3)
            0: insert_pct = 90;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         bias_sel++;
         sender_calm = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(30, 60);
         repeat (burst) begin
            offer_random(insert_pct);
            sent++;
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain, then watch for stray results
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("severity_priority_queue regression: pass");
      end else begin
         $display("severity_priority_queue regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("severity_priority_queue regression: fail");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_channels.sv
hw/rtl/spq_cell.sv
hw/rtl/severity_priority_queue.sv
bench/spq_bench_pkg.sv
bench/tb_top.sv
